// File: src/b64c_pkg.sv
// Package for the crypt-alphabet base-64 encoder.
// Types, group-phase codes and the alphabet lookup shared by all encoder modules.
// No dependencies.
`default_nettype none

package b64c_pkg;

   // Position of the next byte inside its 3-byte group
   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   // One classified byte: one or two 6-bit codes waiting to be sent
   typedef struct packed {
      logic [5:0] code0;
      logic [5:0] code1;
      logic       two;    // code1 is valid
      logic       last;   // code1 is the final character of the message
   } entry_type;

   // Front status, visible to the top level for checks
   typedef struct packed {
      logic [1:0] phase;
      logic [3:0] left;
   } front_status_type;

   // Queue status toward the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Crypt alphabet: "./", A-Z, a-z, 0-9
   function automatic logic [6:0] crypt_char(input logic [5:0] v);
      logic [6:0] wide;
      wide = {1'b0, v};
      if (v < 6'd2) begin
         return 7'd46 + wide;
      end else if (v < 6'd28) begin
         return 7'd63 + wide;
      end else if (v < 6'd54) begin
         return 7'd69 + wide;
      end else begin
         return wide - 7'd6;
      end
   endfunction

endpackage

`default_nettype wire

// File: src/base64_encoder_crypt_alphabet_core.sv
// Top level of the crypt-alphabet base-64 encoder (no padding).
// Depends on b64c_pkg, b64c_front, b64c_queue, b64c_back.
//
//   channel | direction | ports                                   | handshake
//   req     | in        | req_data_byte[7:0], req_end_of_message  | req_valid / req_stall
//   rsp     | out       | rsp_code_char[6:0], rsp_last_char       | rsp_valid / rsp_stall
//
// The front classifies a byte in the cycle it is accepted and pushes it into the
// queue; its first character is loaded into the output register at the edge that pops it.
// The back sends one character per cycle while rsp_stall is low; a byte yielding two
// characters blocks the next pop until its second character is loaded, so the byte
// rate is set by that single output register.
// req_stall rises only when the queue is full. Reset is synchronous; no clearing pass.
`default_nettype none

module base64_encoder_crypt_alphabet_core
   import b64c_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_end_of_message,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_code_char,
   output logic            rsp_last_char
);

   entry_type        front_entry;
   entry_type        head;
   front_status_type front_status;
   queue_status_type queue_status;
   logic             accept;
   logic             pop;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !queue_status.full;

   b64c_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_data_byte),
      .end_of_message (req_end_of_message),
      .entry          (front_entry),
      .status         (front_status)
   );

   b64c_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_entry (front_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   b64c_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (head),
      .head_valid    (!queue_status.empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code_char (rsp_code_char),
      .rsp_last_char (rsp_last_char)
   );

   // Checks
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !queue_status.empty)
      else $error("queue popped while empty");

   a_final_resets_group: assert property (@(posedge clock) disable iff (reset)
      accept && req_end_of_message |=>
         front_status.phase == PHASE_FIRST && front_status.left == 4'd0)
      else $error("group state not cleared after final byte");

   a_phase_reachable: assert property (@(posedge clock) disable iff (reset)
      front_status.phase != 2'd3)
      else $error("group phase reached unused code");

   a_left_narrow_first: assert property (@(posedge clock) disable iff (reset)
      front_status.phase == PHASE_SECOND |-> front_status.left[3:2] == 2'b00)
      else $error("leftover bits too wide after first byte");

endmodule

`default_nettype wire

// File: src/b64c_front.sv
// Front end of the encoder: holds group phase and leftover bits, splits each byte
// into one or two 6-bit codes. Depends on b64c_pkg.
`default_nettype none

module b64c_front
   import b64c_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       data_byte,
   input  wire logic             end_of_message,
   output entry_type             entry,
   output front_status_type      status
);

   logic [1:0] phase_ff, phase_in;
   logic [3:0] left_ff, left_in;

   // Classify the byte by its group position
   always_comb begin
      entry.last = end_of_message;
      case (phase_ff)
         PHASE_SECOND: begin
            entry.code0 = {left_ff[1:0], data_byte[7:4]};
            entry.code1 = {data_byte[3:0], 2'b00};
            entry.two   = end_of_message;
            phase_in    = PHASE_THIRD;
            left_in     = data_byte[3:0];
         end
         PHASE_THIRD: begin
            entry.code0 = {left_ff[3:0], data_byte[7:6]};
            entry.code1 = data_byte[5:0];
            entry.two   = 1'b1;
            phase_in    = PHASE_FIRST;
            left_in     = 4'd0;
         end
         default: begin
            // first position, and the unreachable fourth code
            entry.code0 = data_byte[7:2];
            entry.code1 = {data_byte[1:0], 4'b0000};
            entry.two   = end_of_message;
            phase_in    = PHASE_SECOND;
            left_in     = {2'b00, data_byte[1:0]};
         end
      endcase
      // final byte flushes the group
      if (end_of_message) begin
         phase_in = PHASE_FIRST;
         left_in  = 4'd0;
      end
   end

   // State update on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_FIRST;
         left_ff  <= 4'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   assign status.phase = phase_ff;
   assign status.left  = left_ff;

endmodule

`default_nettype wire

// File: src/b64c_queue.sv
// Short FIFO of classified entries between front and back.
// Depends on b64c_pkg.
`default_nettype none

module b64c_queue
   import b64c_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  entry_type        push_entry,
   input  wire logic        pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// File: src/b64c_back.sv
// Back end of the encoder: sends one character per cycle, while rsp_stall is low,
// from queued entries through a registered output. Depends on b64c_pkg.
`default_nettype none

module b64c_back
   import b64c_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  entry_type        head,
   input  wire logic        head_valid,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [6:0]       rsp_code_char,
   output logic             rsp_last_char
);

   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       pend_ff, pend_in;      // second code still to send
   logic [5:0] pend_code_ff, pend_code_in;
   logic       pend_last_ff, pend_last_in;
   logic       load;

   // Output register may take a new character when empty or being drained
   assign load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in     = valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      pend_in      = pend_ff;
      pend_code_in = pend_code_ff;
      pend_last_in = pend_last_ff;
      pop          = 1'b0;
      if (load) begin
         if (pend_ff) begin
            valid_in = 1'b1;
            char_in  = crypt_char(pend_code_ff);
            last_in  = pend_last_ff;
            pend_in  = 1'b0;
         end else if (head_valid) begin
            pop          = 1'b1;
            valid_in     = 1'b1;
            char_in      = crypt_char(head.code0);
            last_in      = 1'b0;
            pend_in      = head.two;
            pend_code_in = head.code1;
            pend_last_in = head.last;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      pend_code_ff <= pend_code_in;
      pend_last_ff <= pend_last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_code_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

`default_nettype wire
